// ===== src/resonant_two_pole_lowpass_assert.svh =====
// Assertion shorthands shared by the filter's modules.
// Both expect clk in scope; RTPL_ASSERT also expects rst_n.
`ifndef RESONANT_TWO_POLE_LOWPASS_ASSERT_SVH
`define RESONANT_TWO_POLE_LOWPASS_ASSERT_SVH

// Checked only while out of reset.
`define RTPL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define RTPL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rtpl_pkg.sv =====
`default_nettype none

package rtpl_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int RES_BITS        = 16;
  localparam int CUT_BITS        = 16;
  localparam int STAGE_BITS      = 32;
  // Q8.23 stage format: a sample of this many bits maps without shift
  localparam int X_POINT         = 24;
  localparam int FB_BITS         = 24;

  localparam logic [CUT_BITS-1:0] CUT_MIN = 16'd655;
  localparam logic [CUT_BITS-1:0] CUT_MAX = 16'd64880;

  // feedback divider: quotient bits retired per cycle
  localparam int DIV_STEP  = 6;
  localparam int DIV_ITERS = FB_BITS / DIV_STEP;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [STAGE_BITS-1:0] x;
    logic [CUT_BITS-1:0]          cut;
    logic [FB_BITS-1:0]           fb;
  } mid_item_t;

endpackage

`default_nettype wire

// ===== src/rtpl_fifo.sv =====
`default_nettype none

module rtpl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== src/rtpl_front.sv =====
`default_nettype none

module rtpl_front #(
  parameter int SAMPLE_BITS = rtpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic [rtpl_pkg::CUT_BITS-1:0] in_cutoff,
  input  logic [rtpl_pkg::RES_BITS-1:0] resonance,
  output logic                          mid_push,
  input  logic                          mid_full,
  output rtpl_pkg::mid_item_t           mid_data
);

  import rtpl_pkg::*;

  `include "resonant_two_pole_lowpass_assert.svh"

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_HOLD
  } fstate_t;

  localparam int CNT_W     = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;
  localparam int REM_W     = CUT_BITS;
  localparam int NUM_W     = FB_BITS;
  // dividend is r * 2^NUM_SHIFT
  localparam int NUM_SHIFT = 17;
  localparam int HI_SHIFT  = FB_BITS - NUM_SHIFT;

  fstate_t                      st_r;
  logic [CNT_W-1:0]             cnt_r;
  logic signed [STAGE_BITS-1:0] x_r;
  logic [CUT_BITS-1:0]          cut_r;
  logic [REM_W-1:0]             dsr_r;
  logic [REM_W-1:0]             rem_r, rem_nxt;
  logic [NUM_W-1:0]             num_r, num_nxt;
  logic [NUM_W-1:0]             quo_r, quo_nxt;
  logic [FB_BITS-1:0]           fb_r, fb_nxt;
  logic [REM_W:0]               trial;

  logic signed [STAGE_BITS-1:0] x_ext;
  logic [CUT_BITS-1:0]          cut_cl;
  logic [REM_W-1:0]             divisor;
  logic [REM_W-1:0]             rem_init;
  logic [NUM_W-1:0]             num_init;

  // sample to Q8.23
  if (SAMPLE_BITS <= X_POINT) begin : g_up
    assign x_ext = STAGE_BITS'(in_sample_in) <<< (X_POINT - SAMPLE_BITS);
  end else begin : g_dn
    assign x_ext = STAGE_BITS'(in_sample_in >>> (SAMPLE_BITS - X_POINT));
  end

  always_comb begin
    priority if (in_cutoff < CUT_MIN) begin
      cut_cl = CUT_MIN;
    end else if (in_cutoff > CUT_MAX) begin
      cut_cl = CUT_MAX;
    end else begin
      cut_cl = in_cutoff;
    end
  end

  // 1 - f in Q0.16; never zero after the clamp
  assign divisor  = REM_W'({1'b1, {CUT_BITS{1'b0}}} - {1'b0, cut_cl});
  assign rem_init = REM_W'(resonance >> HI_SHIFT);
  assign num_init = {resonance[HI_SHIFT-1:0], {NUM_SHIFT{1'b0}}};

  // restoring division, DIV_STEP quotient bits per cycle
  always_comb begin
    rem_nxt = rem_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial   = {rem_nxt, num_nxt[NUM_W-1]};
      num_nxt = {num_nxt[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = REM_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_nxt[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[REM_W-1:0];
        quo_nxt = {quo_nxt[NUM_W-2:0], 1'b0};
      end
    end
  end

  // fb = r + r/(1-f) in Q8.16; stays below 2^24 for 16-bit r
  assign fb_nxt = FB_BITS'({resonance, 1'b0}) + quo_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        F_IDLE: begin
          if (in_push) begin
            x_r   <= x_ext;
            cut_r <= cut_cl;
            dsr_r <= divisor;
            rem_r <= rem_init;
            num_r <= num_init;
            quo_r <= '0;
            cnt_r <= '0;
            st_r  <= F_DIV;
          end
        end
        F_DIV: begin
          rem_r <= rem_nxt;
          num_r <= num_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_ITERS - 1)) begin
            fb_r <= fb_nxt;
            st_r <= F_HOLD;
          end
        end
        F_HOLD: begin
          if (!mid_full) begin
            st_r <= F_IDLE;
          end
        end
        default: begin
          st_r <= F_IDLE;
        end
      endcase
    end
  end

  assign in_full  = (st_r != F_IDLE);
  assign mid_push = (st_r == F_HOLD);
  assign mid_data = '{x: x_r, cut: cut_r, fb: fb_r};

  `RTPL_ASSERT(a_acc_busy, (in_push && !in_full) |=> in_full, "front took a second item")
  `RTPL_ASSERT(a_div_len, (st_r == F_DIV && cnt_r == CNT_W'(DIV_ITERS - 1)) |=> mid_push,
               "divider ran past its iteration count")
  `RTPL_ASSERT(a_hold_stall, (mid_push && mid_full) |=> (mid_push && $stable(mid_data)),
               "stalled front item changed")

endmodule

`default_nettype wire

// ===== src/rtpl_back.sv =====
`default_nettype none

module rtpl_back #(
  parameter int SAMPLE_BITS = rtpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mid_empty,
  output logic                          mid_pop,
  input  rtpl_pkg::mid_item_t           mid_data,
  output logic                          res_push,
  input  logic                          res_full,
  output logic signed [SAMPLE_BITS-1:0] res_sample,
  output logic                          res_clip
);

  import rtpl_pkg::*;

  `include "resonant_two_pole_lowpass_assert.svh"

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL_FB,
    B_SUM,
    B_MUL_IN,
    B_UPD1,
    B_MUL_D2,
    B_UPD2,
    B_EMIT
  } bstate_t;

  localparam int D_W  = STAGE_BITS + 1;
  localparam int P1_W = FB_BITS + 1 + D_W;
  localparam int IN_W = 44;
  localparam int P2_W = CUT_BITS + 1 + IN_W;
  localparam int P3_W = CUT_BITS + 1 + D_W;
  localparam int PR_W = P2_W;
  localparam int SH   = 16;
  localparam int YW   = STAGE_BITS + ((SAMPLE_BITS > X_POINT) ? SAMPLE_BITS - X_POINT : 0);

  localparam logic signed [YW-1:0] Y_MAX = YW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [YW-1:0] Y_MIN = YW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  bstate_t                      st_r;
  logic signed [STAGE_BITS-1:0] fs_r, ss_r;
  logic signed [STAGE_BITS-1:0] x_r;
  logic [CUT_BITS-1:0]          cut_r;
  logic [FB_BITS-1:0]           fb_r;
  logic signed [PR_W-1:0]       prod_r;
  logic signed [IN_W-1:0]       inner_r;

  logic signed [D_W-1:0]        d_w;
  logic signed [P1_W-1:0]       mul_fb;
  logic signed [IN_W-1:0]       sum_in;
  logic signed [P2_W-1:0]       mul_in;
  logic signed [P3_W-1:0]       mul_d2;
  logic signed [63:0]           upd1_sum, upd2_sum;
  logic signed [YW-1:0]         y_w;

  function automatic logic signed [STAGE_BITS-1:0] sat_stage(input logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    priority if (v > hi) begin
      return STAGE_BITS'(hi);
    end else if (v < lo) begin
      return STAGE_BITS'(lo);
    end else begin
      return STAGE_BITS'(v);
    end
  endfunction

  assign d_w      = D_W'(fs_r) - D_W'(ss_r);
  assign mul_fb   = $signed({1'b0, fb_r}) * d_w;
  assign sum_in   = IN_W'(x_r) - IN_W'(fs_r) + IN_W'(prod_r >>> SH);
  assign mul_in   = $signed({1'b0, cut_r}) * inner_r;
  assign mul_d2   = $signed({1'b0, cut_r}) * d_w;
  assign upd1_sum = 64'(fs_r) + 64'(prod_r >>> SH);
  assign upd2_sum = 64'(ss_r) + 64'(prod_r >>> SH);

  // Q8.23 back to the sample format
  if (SAMPLE_BITS <= X_POINT) begin : g_dn
    assign y_w = ss_r >>> (X_POINT - SAMPLE_BITS);
  end else begin : g_up
    assign y_w = YW'(ss_r) <<< (SAMPLE_BITS - X_POINT);
  end

  always_comb begin
    priority if (y_w > Y_MAX) begin
      res_sample = SAMPLE_BITS'(Y_MAX);
      res_clip   = 1'b1;
    end else if (y_w < Y_MIN) begin
      res_sample = SAMPLE_BITS'(Y_MIN);
      res_clip   = 1'b1;
    end else begin
      res_sample = SAMPLE_BITS'(y_w);
      res_clip   = 1'b0;
    end
  end

  assign mid_pop  = (st_r == B_IDLE) && !mid_empty;
  assign res_push = (st_r == B_EMIT) && !res_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      fs_r <= '0;
      ss_r <= '0;
    end else begin
      unique case (st_r)
        B_IDLE: begin
          if (!mid_empty) begin
            x_r   <= mid_data.x;
            cut_r <= mid_data.cut;
            fb_r  <= mid_data.fb;
            st_r  <= B_MUL_FB;
          end
        end
        B_MUL_FB: begin
          prod_r <= PR_W'(mul_fb);
          st_r   <= B_SUM;
        end
        B_SUM: begin
          inner_r <= sum_in;
          st_r    <= B_MUL_IN;
        end
        B_MUL_IN: begin
          prod_r <= PR_W'(mul_in);
          st_r   <= B_UPD1;
        end
        B_UPD1: begin
          fs_r <= sat_stage(upd1_sum);
          st_r <= B_MUL_D2;
        end
        B_MUL_D2: begin
          prod_r <= PR_W'(mul_d2);
          st_r   <= B_UPD2;
        end
        B_UPD2: begin
          ss_r <= sat_stage(upd2_sum);
          st_r <= B_EMIT;
        end
        B_EMIT: begin
          if (!res_full) begin
            st_r <= B_IDLE;
          end
        end
        default: begin
          st_r <= B_IDLE;
        end
      endcase
    end
  end

  `RTPL_ASSERT_ALWAYS(a_res_room, !(res_push && res_full), "result pushed into full queue")
  `RTPL_ASSERT(a_clip_rail, (res_push && res_clip) |->
               (res_sample == SAMPLE_BITS'(Y_MAX) || res_sample == SAMPLE_BITS'(Y_MIN)),
               "clip flag without a rail value")
  `RTPL_ASSERT(a_fs_hold, (st_r != B_UPD1) |=> $stable(fs_r),
               "first stage changed outside its update step")

endmodule

`default_nettype wire

// ===== src/resonant_two_pole_lowpass.sv =====
// Two-pole resonant lowpass, fixed point.
// Input channel: in_push / in_full carry one item (in_sample_in, signed Q1.15 at the
//   default width, and in_cutoff, unsigned Q0.16, clamped to 0.01..0.99).
// Result channel: while out_empty is low the oldest result (out_sample_out, out_clipped)
//   is on the ports; out_pop takes it.
// Config: cfg_valid / cfg_ready write the resonance register (Q1.15); cfg_ready is
//   always high. Write it only while no item is in flight.
// The back end's sequencer sets the throughput: it takes a new item only after
//   emitting the last, and runs the three dependent multiplies of the recurrence one
//   after another, the first followed by an add step, the others by an add and
//   saturate step each. The front end accepts an item, runs four divider passes of 6
//   quotient bits for the feedback term and hands off before it takes the next item.
// A two-entry queue sits between front and back, another one on the result side, so
//   a stalled receiver only stops the back end once that queue fills; the front
//   keeps computing feedback terms until the middle queue is full too.
// Reset (synchronous, rst_n low) zeroes both filter stages and the resonance and
//   empties both queues.
`default_nettype none

module resonant_two_pole_lowpass #(
  parameter int SAMPLE_BITS = rtpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic [rtpl_pkg::CUT_BITS-1:0] in_cutoff,
  // result channel
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_clipped,
  // resonance write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rtpl_pkg::RES_BITS-1:0] cfg_resonance
);

  import rtpl_pkg::*;

  localparam int MID_W = $bits(mid_item_t);
  localparam int OUT_W = SAMPLE_BITS + 1;

  logic [RES_BITS-1:0]          res_r;

  // front -> middle queue
  logic                         mid_push, mid_full;
  mid_item_t                    mid_wdata;
  // middle queue -> back
  logic                         mid_pop, mid_empty;
  logic [MID_W-1:0]             mid_rvec;
  mid_item_t                    mid_rdata;
  // back -> result queue
  logic                         res_push, res_full;
  logic signed [SAMPLE_BITS-1:0] res_sample;
  logic                         res_clip;
  logic [OUT_W-1:0]             out_rvec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (cfg_valid) begin
      res_r <= cfg_resonance;
    end
  end

  rtpl_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_sample_in (in_sample_in),
    .in_cutoff    (in_cutoff),
    .resonance    (res_r),
    .mid_push     (mid_push),
    .mid_full     (mid_full),
    .mid_data     (mid_wdata)
  );

  rtpl_fifo #(
    .WIDTH (MID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rvec),
    .empty (mid_empty)
  );

  assign mid_rdata = mid_item_t'(mid_rvec);

  rtpl_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mid_empty  (mid_empty),
    .mid_pop    (mid_pop),
    .mid_data   (mid_rdata),
    .res_push   (res_push),
    .res_full   (res_full),
    .res_sample (res_sample),
    .res_clip   (res_clip)
  );

  // result queue holds {clip, sample}
  rtpl_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_clip, res_sample}),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_rvec),
    .empty (out_empty)
  );

  assign out_sample_out = out_rvec[SAMPLE_BITS-1:0];
  assign out_clipped    = out_rvec[SAMPLE_BITS];

endmodule

`default_nettype wire

// ===== tb/sv/tb_resonant_two_pole_lowpass.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the two-pole resonant lowpass.
// A local fixed-point filter model tracks both stages and predicts every output
// item; the block's results are compared in order, field by field.
module tb_resonant_two_pole_lowpass;
  import rtpl_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;      // catches stray results after the drain
  localparam int N_DIRECTED   = 22;
  localparam int N_PHASES     = 6;

  // Output item as predicted / as seen on the result ports
  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic                 clip;
  } filt_out_t;

  // One directed row: resonance in force, input item, and optionally a
  // hand-written expected output (only where it is obvious from zero state).
  typedef struct packed {
    logic [RES_BITS-1:0] res;
    logic [SB-1:0]       smp;
    logic [CUT_BITS-1:0] cut;
    logic                typed;
    logic [SB-1:0]       out_smp;
    logic                out_clip;
  } dir_row_t;

  // Receiver behavior, chosen anew for each segment
  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_COIN,
    POP_EVERY_4TH,
    POP_LONG_STALLS
  } pop_mode_t;

  // ---------------------------------------------------------------------------
  // Clock, DUT signals
  // ---------------------------------------------------------------------------
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_push        = 1'b0;
  logic                 in_full;
  logic signed [SB-1:0] in_sample_in   = '0;
  logic [CUT_BITS-1:0]  in_cutoff      = '0;
  logic                 out_empty;
  logic                 out_pop        = 1'b0;
  logic signed [SB-1:0] out_sample_out;
  logic                 out_clipped;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [RES_BITS-1:0]  cfg_resonance  = '0;

  always #5 clk = ~clk;

  resonant_two_pole_lowpass uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_sample_in   (in_sample_in),
    .in_cutoff      (in_cutoff),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_resonance  (cfg_resonance)
  );

  // ---------------------------------------------------------------------------
  // Filter model state and bookkeeping
  // ---------------------------------------------------------------------------
  logic signed [STAGE_BITS-1:0] stage1_q;   // Q8.23
  logic signed [STAGE_BITS-1:0] stage2_q;   // Q8.23
  logic [RES_BITS-1:0]          res_q;      // resonance as last written
  filt_out_t                    expected_q[$];

  int  n_items;
  int  n_results;
  int  n_errors;
  int  n_cfg_writes;
  int  n_clamped;        // items whose cutoff fell outside 0.01..0.99
  int  n_stage_sat;      // stage updates that hit the 32-bit rails
  int  n_clip_items;     // items predicted to clip at the output
  int  cycles;

  // sender pacing
  bit  drive_push;
  int  burst_left;

  // Saturate a stage update to signed 32 bits; the rails do not flag clipping.
  function automatic logic signed [STAGE_BITS-1:0] sat_stage(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (STAGE_BITS - 1)) - 1;
    lo = -(longint'(1) <<< (STAGE_BITS - 1));
    if (v > hi) begin
      n_stage_sat++;
      return hi[STAGE_BITS-1:0];
    end
    if (v < lo) begin
      n_stage_sat++;
      return lo[STAGE_BITS-1:0];
    end
    return v[STAGE_BITS-1:0];
  endfunction

  // Advance the model by one input item and return the output item it makes.
  // All products are exact in 64 bits; >>> on longint gives floor rounding.
  function automatic filt_out_t advance_filter(input logic signed [SB-1:0] smp,
                                               input logic [CUT_BITS-1:0] cut);
    longint    x;
    longint    f;
    longint    r;
    longint    fb;
    longint    d;
    longint    inner;
    longint    y;
    longint    lim;
    filt_out_t res;

    x = longint'(smp) <<< (X_POINT - SB);        // sample to Q8.23
    f = longint'(cut);
    r = longint'(res_q);

    // cutoff clamp to 0.01 .. 0.99
    if (f < longint'(CUT_MIN) || f > longint'(CUT_MAX))
      n_clamped++;
    if (f < longint'(CUT_MIN))
      f = longint'(CUT_MIN);
    if (f > longint'(CUT_MAX))
      f = longint'(CUT_MAX);

    // feedback: r + r / (1 - f), Q8.16, saturating
    fb = 2 * r + (r * 131072) / (65536 - f);
    if (fb > (longint'(1) <<< FB_BITS) - 1)
      fb = (longint'(1) <<< FB_BITS) - 1;

    // stage one sees the input plus resonant feedback
    d        = longint'(stage1_q) - longint'(stage2_q);
    inner    = x - longint'(stage1_q) + ((fb * d) >>> 16);
    stage1_q = sat_stage(longint'(stage1_q) + ((f * inner) >>> 16));

    // stage two follows the already updated stage one
    d        = longint'(stage1_q) - longint'(stage2_q);
    stage2_q = sat_stage(longint'(stage2_q) + ((f * d) >>> 16));

    // back to the sample format, saturating
    y        = longint'(stage2_q) >>> (X_POINT - SB);
    lim      = longint'(1) <<< (SB - 1);
    res.clip = 1'b0;
    if (y > lim - 1) begin
      y        = lim - 1;
      res.clip = 1'b1;
    end else if (y < -lim) begin
      y        = -lim;
      res.clip = 1'b1;
    end
    res.smp = y[SB-1:0];
    if (res.clip)
      n_clip_items++;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic drop_push();
    if (drive_push) begin
      in_push    <= 1'b0;
      drive_push  = 1'b0;
    end
  endtask

  // Offer one item, wait for it to be taken, record its expected output.
  // Gaps come between bursts and are never empty, so push is not lowered and
  // raised within the same edge.
  task automatic push_sample(input logic signed [SB-1:0] smp,
                             input logic [CUT_BITS-1:0] cut,
                             input bit                  typed,
                             input filt_out_t           typed_out);
    filt_out_t pred;
    in_push      <= 1'b1;
    drive_push    = 1'b1;
    in_sample_in <= smp;
    in_cutoff    <= cut;
    @(posedge clk);
    while (in_full)
      @(posedge clk);
    pred = advance_filter(smp, cut);
    expected_q.push_back(typed ? typed_out : pred);
    n_items++;
    burst_left--;
    if (burst_left <= 0) begin
      drop_push();
      repeat ($urandom_range(1, 14)) @(posedge clk);
      // about one burst in four is a long unbroken stretch
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
    end
  endtask

  // Resonance may only change with nothing in flight: wait until every
  // expected item has come back, then do the write handshake.
  task automatic write_resonance(input logic [RES_BITS-1:0] val);
    drop_push();
    while (expected_q.size() != 0)
      @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_resonance <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    res_q      = val;
    n_cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: the pop mode is drawn anew for each segment of clock cycles
  // ---------------------------------------------------------------------------
  initial begin
    pop_mode_t mode;
    int        seg_len;
    int        stall_left;
    logic      pop_v;
    stall_left = 0;
    wait (rst_n);
    forever begin
      mode    = pop_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(40, 300);
      for (int i = 0; i < seg_len; i++) begin
        @(posedge clk);
        case (mode)
          POP_ALWAYS:    pop_v = 1'b1;
          POP_COIN:      pop_v = $urandom_range(0, 1);
          POP_EVERY_4TH: pop_v = (i % 4) == 0;
          default: begin
            if (stall_left > 0) begin
              pop_v = 1'b0;
              stall_left--;
            end else begin
              pop_v = 1'b1;
              if ($urandom_range(0, 2) == 0)
                stall_left = $urandom_range(5, 30);
            end
          end
        endcase
        out_pop <= pop_v;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every popped item against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    filt_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item sample_out=%0d clipped=%0b", $time,
                 out_sample_out, out_clipped);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        n_results++;
        if (out_sample_out !== want.smp) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, want.smp,
                   out_sample_out);
          n_errors++;
        end
        if (out_clipped !== want.clip) begin
          $display("%0t: clipped expected %0b, got %0b", $time, want.clip,
                   out_clipped);
          n_errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d items still expected", $time, expected_q.size());
      $display("resonant_two_pole_lowpass: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Directed rows:
  //  - zero input from reset state must give exactly zero (typed in)
  //  - cutoff at and just past both clamp edges, both sample extremes
  //  - resonance at 1.0 and at the top of the register (about 2.0); the latter
  //    with cutoff near 0.99 drives the stages into their rails and clips
  //  - resonance back to zero with silence to let the stages recover
  dir_row_t dir_rows[N_DIRECTED] = '{
    '{16'd0,     16'h0000, 16'd0,     1'b1, 16'h0000, 1'b0},
    '{16'd0,     16'h0000, 16'd65535, 1'b1, 16'h0000, 1'b0},
    '{16'd0,     16'h7FFF, 16'd65535, 1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'h7FFF, 16'd64880, 1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'h7FFF, 16'd64881, 1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'h8000, 16'd0,     1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'h8000, 16'd654,   1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'h8000, 16'd655,   1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'h8000, 16'd656,   1'b0, 16'h0000, 1'b0},
    '{16'd32768, 16'h7FFF, 16'd40000, 1'b0, 16'h0000, 1'b0},
    '{16'd32768, 16'h8000, 16'd40000, 1'b0, 16'h0000, 1'b0},
    '{16'd32768, 16'h7FFF, 16'd64879, 1'b0, 16'h0000, 1'b0},
    '{16'd65535, 16'h7FFF, 16'd65535, 1'b0, 16'h0000, 1'b0},
    '{16'd65535, 16'h8000, 16'd65535, 1'b0, 16'h0000, 1'b0},
    '{16'd65535, 16'h7FFF, 16'd65535, 1'b0, 16'h0000, 1'b0},
    '{16'd65535, 16'h8000, 16'd65535, 1'b0, 16'h0000, 1'b0},
    '{16'd65535, 16'h7FFF, 16'd64880, 1'b0, 16'h0000, 1'b0},
    '{16'd65535, 16'h0000, 16'd0,     1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'h0000, 16'd65535, 1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'h0000, 16'd65535, 1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'h0001, 16'd32768, 1'b0, 16'h0000, 1'b0},
    '{16'd0,     16'hFFFF, 16'd32768, 1'b0, 16'h0000, 1'b0}
  };

  initial begin
    filt_out_t           typed_out;
    logic [RES_BITS-1:0] phase_res[N_PHASES];
    int                  phase_len[N_PHASES];
    logic signed [SB-1:0] held;
    logic signed [SB-1:0] smp;
    logic [CUT_BITS-1:0]  cut;
    int                   pick;

    stage1_q   = '0;
    stage2_q   = '0;
    res_q      = '0;
    drive_push = 1'b0;
    burst_left = $urandom_range(1, 24);
    held       = '0;

    // Phase plan: resonance 1.0, off, maximum, random, smallest step, random.
    // The maximum-resonance phase is short since the filter just rails there.
    phase_res = '{16'd32768, 16'd0, 16'd65535, RES_BITS'($urandom_range(0, 65535)),
                  16'd1, RES_BITS'($urandom_range(0, 65535))};
    phase_len = '{200, 150, 60, 170, 150, 170};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].res != res_q)
        write_resonance(dir_rows[i].res);
      typed_out.smp  = dir_rows[i].out_smp;
      typed_out.clip = dir_rows[i].out_clip;
      push_sample(dir_rows[i].smp, dir_rows[i].cut, dir_rows[i].typed, typed_out);
    end

    // Random phases, each under its own resonance setting
    for (int p = 0; p < N_PHASES; p++) begin
      write_resonance(phase_res[p]);
      for (int k = 0; k < phase_len[p]; k++) begin
        // samples: full range, rails, held steps (lets the filter settle and
        // ring), or small signals near zero
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0)
          held = SB'($urandom_range(0, (1 << SB) - 1));
        if (pick < 40)
          smp = SB'($urandom_range(0, (1 << SB) - 1));
        else if (pick < 55)
          smp = $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
        else if (pick < 80)
          smp = held;
        else
          smp = SB'($urandom_range(0, 1024)) - SB'(512);

        // cutoff: full range, below the floor, above the ceiling, at the edges
        pick = $urandom_range(0, 99);
        if (pick < 60)
          cut = CUT_BITS'($urandom_range(0, 65535));
        else if (pick < 75)
          cut = CUT_BITS'($urandom_range(0, 654));
        else if (pick < 90)
          cut = CUT_BITS'($urandom_range(64881, 65535));
        else
          cut = $urandom_range(0, 1) ? CUT_MIN + CUT_BITS'($urandom_range(0, 2)) - 1'b1
                                     : CUT_MAX + CUT_BITS'($urandom_range(0, 2)) - 1'b1;

        typed_out = '0;
        push_sample(smp, cut, 1'b0, typed_out);
      end
    end

    // Drain, then keep watching for anything extra to show up
    drop_push();
    while (expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d items in, %0d results checked, %0d resonance writes, %0d errors",
             n_items, n_results, n_cfg_writes, n_errors);
    $display("Seen: %0d clamped cutoffs, %0d output clips, %0d stage saturations",
             n_clamped, n_clip_items, n_stage_sat);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("resonant_two_pole_lowpass: match");
    else
      $display("resonant_two_pole_lowpass: mismatch");
    $finish;
  end

endmodule

// ===== resonant_two_pole_lowpass.f =====
+incdir+src
src/rtpl_pkg.sv
src/rtpl_fifo.sv
src/rtpl_front.sv
src/rtpl_back.sv
src/resonant_two_pole_lowpass.sv
tb/sv/tb_resonant_two_pole_lowpass.sv
